@@ src/bit_matrix_rotate_transpose_cipher_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef BIT_MATRIX_ROTATE_TRANSPOSE_CIPHER_MACROS_SVH
`define BIT_MATRIX_ROTATE_TRANSPOSE_CIPHER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BMRTC_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define BMRTC_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

@@ src/bmrtc_pkg.sv @@
// Shared constants, types and functions of the rotate-transpose cipher.
package bmrtc_pkg;
	localparam int unsigned NWORDS = 32;
	localparam int unsigned W      = 32;
	localparam int unsigned IDXW   = $clog2(NWORDS);
	localparam int unsigned ROUNDS = 8;
	localparam int unsigned RBITS  = $clog2(ROUNDS);
	localparam int unsigned AMTW   = 5;
	// folded key residue, reciprocal width and shift for an exact quotient
	localparam int unsigned REMW   = 16;
	localparam int unsigned RECW   = 17;
	localparam int unsigned RSHIFT = 22;
	localparam int unsigned PRODW  = REMW + RECW;

	typedef logic [W-1:0] word_t;
	typedef logic [NWORDS-1:0][2:0][5:0] pmod_tab_t;
	typedef logic [NWORDS-1:0][RECW-1:0] recip_tab_t;

	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_RDA   = 6'b000010,
		ST_CAP   = 6'b000100,
		ST_MOD   = 6'b001000,
		ST_APPLY = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	typedef struct packed {
		logic            load_row;
		logic [IDXW-1:0] row_idx;
		logic            cap_key;
		logic            cap_xor;
		logic            mod_step;
		logic            apply;
		logic            ev_left;
		logic            dec;
		logic            shift_out;
	} cmd_t;

	// 2^(8i) mod (32+j) for key bytes 1..3
	function automatic pmod_tab_t pmod_tab();
		pmod_tab_t t;
		for (int j = 0; j < NWORDS; j++)
			for (int i = 0; i < 3; i++)
				t[j][i] = 6'((64'd1 << (8 * (i + 1))) % 64'(NWORDS + j));
		return t;
	endfunction

	// ceil(2^RSHIFT / (32+j))
	function automatic recip_tab_t recip_tab();
		recip_tab_t t;
		for (int j = 0; j < NWORDS; j++)
			t[j] = RECW'(((64'd1 << RSHIFT) + 64'(NWORDS + j) - 64'd1) / 64'(NWORDS + j));
		return t;
	endfunction

	localparam pmod_tab_t  PMOD  = pmod_tab();
	localparam recip_tab_t RECIP = recip_tab();

	function automatic word_t byte_rev(word_t w);
		word_t o;
		o = '0;
		for (int b = 0; b < W; b++)
			o[(b & ~7) | (7 - (b & 7))] = w[b];
		return o;
	endfunction

	function automatic word_t rotate(word_t x, logic [4:0] a, logic left);
		logic [2*W-1:0] d;
		d = {x, x};
		if (left) begin
			d = d << a;
			return d[2*W-1:W];
		end else begin
			d = d >> a;
			return d[W-1:0];
		end
	endfunction

	// Key folded to a 16-bit value congruent to it mod (32+j).
	function automatic logic [REMW-1:0] fold_key(word_t k, int unsigned j);
		logic [REMW-1:0] s;
		s = REMW'(k[7:0]);
		for (int i = 1; i < 4; i++)
			s = s + REMW'(k[8*i +: 8]) * REMW'(PMOD[j][i-1]);
		return s;
	endfunction

	// (s mod (32+j)) mod 32 through the reciprocal quotient.
	function automatic logic [AMTW-1:0] rem_amount(logic [REMW-1:0] s, int unsigned j);
		logic [PRODW-1:0] p;
		logic [AMTW-1:0]  q;
		p = PRODW'(s) * PRODW'(RECIP[j]);
		q = p[RSHIFT +: AMTW];
		// (32+j) mod 32 is j, so only the low quotient bits matter
		return s[AMTW-1:0] - q * AMTW'(j);
	endfunction
endpackage

@@ src/bmrtc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bmrtc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ src/bmrtc_dp.sv @@
// Datapath: bit matrix, rotation amount lanes, rotate/transpose step, output row.
module bmrtc_dp (
	input  logic           clk,
	input  bmrtc_pkg::cmd_t cmd,
	input  bmrtc_pkg::word_t word,
	input  bmrtc_pkg::word_t rdata,
	output bmrtc_pkg::word_t out_word
);
	import bmrtc_pkg::*;

	word_t           mat_q [NWORDS];
	logic [REMW-1:0] rem_q [NWORDS];
	logic [AMTW-1:0] amt_q [NWORDS];
	word_t           kx_q;
	word_t           stage_a [NWORDS];
	word_t           mat_next [NWORDS];

	always_comb begin
		for (int j = 0; j < NWORDS; j++) begin
			if (cmd.dec)
				for (int k = 0; k < NWORDS; k++)
					stage_a[j][k] = mat_q[k][j];
			else
				stage_a[j] = rotate(mat_q[j], amt_q[j], cmd.ev_left ^ 1'(j & 1));
		end
		stage_a[NWORDS-1] = stage_a[NWORDS-1] ^ kx_q;
		for (int j = 0; j < NWORDS; j++) begin
			if (cmd.dec)
				mat_next[j] = rotate(stage_a[j], amt_q[j], cmd.ev_left ^ 1'(j & 1));
			else
				for (int k = 0; k < NWORDS; k++)
					mat_next[j][k] = stage_a[k][j];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_row)
			mat_q[cmd.row_idx] <= cmd.dec ? word : byte_rev(word);
		else if (cmd.apply)
			mat_q <= mat_next;
		else if (cmd.shift_out) begin
			for (int j = 0; j < NWORDS - 1; j++)
				mat_q[j] <= mat_q[j+1];
		end
		if (cmd.cap_key) begin
			for (int j = 0; j < NWORDS; j++)
				rem_q[j] <= fold_key(rdata, j);
		end
		if (cmd.mod_step) begin
			for (int j = 0; j < NWORDS; j++)
				amt_q[j] <= rem_amount(rem_q[j], j);
		end
		if (cmd.cap_xor)
			kx_q <= rdata;
	end

	assign out_word = cmd.dec ? byte_rev(mat_q[0]) : mat_q[0];
endmodule

@@ src/bmrtc_ctrl.sv @@
// Controller: load counters, round sequencer and output handshake.
module bmrtc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   func,
	input  logic                   out_stall,
	input  logic                   cfg_valid,
	input  logic                   cfg_data,
	output logic                   in_stall,
	output logic                   out_valid,
	output logic                   last,
	output logic                   cfg_ready,
	output logic                   key_we,
	output logic [bmrtc_pkg::IDXW-1:0] key_waddr,
	output logic [bmrtc_pkg::IDXW-1:0] key_raddr,
	output bmrtc_pkg::cmd_t         cmd
);
	import bmrtc_pkg::*;

	state_t           state_q;
	logic [IDXW-1:0]  key_cnt_q;
	logic [IDXW-1:0]  row_cnt_q;
	logic [IDXW-1:0]  oidx_q;
	logic [RBITS-1:0] rnd_q;
	logic             half_q;
	logic             dir_q;
	logic             in_xfer;
	logic             out_xfer;
	logic [RBITS-1:0] rr;

	assign in_stall  = (state_q != ST_LOAD);
	assign out_valid = (state_q == ST_OUT);
	assign last      = out_valid && (oidx_q == IDXW'(NWORDS - 1));
	assign cfg_ready = (state_q == ST_LOAD);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid && !out_stall;
	assign key_we    = in_xfer && !func;
	assign key_waddr = key_cnt_q;

	// decrypt walks the rounds backward and swaps the key pairs
	assign rr        = dir_q ? RBITS'(ROUNDS - 1) - rnd_q : rnd_q;
	assign key_raddr = IDXW'({rr, dir_q ^ half_q, state_q == ST_CAP});

	always_comb begin
		cmd.load_row  = in_xfer && func;
		cmd.row_idx   = row_cnt_q;
		cmd.cap_key   = (state_q == ST_CAP);
		cmd.cap_xor   = (state_q == ST_MOD);
		cmd.mod_step  = (state_q == ST_MOD);
		cmd.apply     = (state_q == ST_APPLY);
		cmd.ev_left   = !half_q;
		cmd.dec       = dir_q;
		cmd.shift_out = out_xfer;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			key_cnt_q <= '0;
			row_cnt_q <= '0;
			oidx_q    <= '0;
			rnd_q     <= '0;
			half_q    <= 1'b0;
			dir_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				dir_q <= cfg_data;
			unique case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (!func)
							key_cnt_q <= key_cnt_q + 1'b1;
						else begin
							row_cnt_q <= row_cnt_q + 1'b1;
							if (row_cnt_q == IDXW'(NWORDS - 1))
								state_q <= ST_RDA;
						end
					end
				end
				ST_RDA: state_q <= ST_CAP;
				ST_CAP: state_q <= ST_MOD;
				ST_MOD: state_q <= ST_APPLY;
				ST_APPLY: begin
					half_q <= !half_q;
					if (half_q) begin
						rnd_q <= rnd_q + 1'b1;
						if (rnd_q == RBITS'(ROUNDS - 1)) begin
							oidx_q  <= '0;
							state_q <= ST_OUT;
						end else
							state_q <= ST_RDA;
					end else
						state_q <= ST_RDA;
				end
				ST_OUT: begin
					if (out_xfer) begin
						oidx_q <= oidx_q + 1'b1;
						if (last)
							state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

@@ src/bit_matrix_rotate_transpose_cipher.sv @@
// Each round half: key read, key capture and byte fold, remainder finish with
// xor-key capture, then apply. Sixteen round halves make up the processing.
// Per block: input transfers, round processing, output transfers; no new input
// is taken until the last result word has been transferred.
// Reset clears the counters, the sequencer and direction; key and matrix
// contents stay undefined until written.
module bit_matrix_rotate_transpose_cipher (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   func,
	input  logic [31:0]            word,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [31:0]            out_word,
	output logic                   last,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data
);
	import bmrtc_pkg::*;

	cmd_t            cmd;
	logic            key_we;
	logic [IDXW-1:0] key_waddr;
	logic [IDXW-1:0] key_raddr;
	word_t           key_rdata;

	bmrtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.last      (last),
		.cfg_ready (cfg_ready),
		.key_we    (key_we),
		.key_waddr (key_waddr),
		.key_raddr (key_raddr),
		.cmd       (cmd)
	);

	bmrtc_ram #(
		.WIDTH (W),
		.DEPTH (NWORDS)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (byte_rev(word)),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	bmrtc_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.word     (word),
		.rdata    (key_rdata),
		.out_word (out_word)
	);
endmodule

@@ src/bmrtc_checker.sv @@
// Port-level checker for the cipher top level, with its bind.
`include "bit_matrix_rotate_transpose_cipher_macros.svh"

module bmrtc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] out_word,
	input logic        last
);
	`BMRTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`BMRTC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word) && $stable(last))
	`BMRTC_ASSERT_NOW(a_no_input_while_output, out_valid, in_stall)
	`BMRTC_ASSERT_NEXT(a_last_ends_block, out_valid && !out_stall && last, !out_valid)
endmodule

bind bit_matrix_rotate_transpose_cipher bmrtc_checker u_bmrtc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word),
	.last      (last)
);
